// ----- hdl/ubrp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the usage burn-rate predictor.
package ubrp_pkg;

   localparam int unsigned TIME_BITS    = 48;
   localparam int unsigned USED_BITS    = 16;
   localparam int unsigned RESET_BITS   = 24;
   localparam int unsigned RATE_BITS    = 32;
   localparam int unsigned ETA_BITS     = 32;
   localparam int unsigned MS_BITS      = 10;     // bits to hold MS_PER_S
   localparam int unsigned MS_PER_S     = 1000;
   localparam int unsigned GAP_MIN_MS   = 1000;
   localparam int unsigned SMOOTH_DIV   = 5;      // rate = (3 old + 2 new) / 5
   localparam int unsigned RATE_MIN_INV = 10000;  // rates at most 1/10000 unit/s predict nothing

   typedef struct packed {
      logic [USED_BITS-1:0]  used_short;
      logic [USED_BITS-1:0]  limit_short;
      logic [USED_BITS-1:0]  used_long;
      logic [USED_BITS-1:0]  limit_long;
      logic [RESET_BITS-1:0] reset_short_s;
      logic [RESET_BITS-1:0] reset_long_s;
      logic [TIME_BITS-1:0]  update_ms;
      logic [TIME_BITS-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic                runout_warn;
      logic                exhaust_window;
      logic [ETA_BITS-1:0] runout_eta_s;
   } rsp_type;

   // Projection of both windows, handed from the core to the result stage.
   typedef struct packed {
      logic [ETA_BITS-1:0]   eta_short;
      logic [ETA_BITS-1:0]   eta_long;
      logic [RESET_BITS-1:0] rem_short;
      logic [RESET_BITS-1:0] rem_long;
   } proj_type;

endpackage

// ----- hdl/usage_burn_rate_predictor.sv -----
`timescale 1ns / 1ps
// Top level of the usage burn-rate predictor: handshake and result register.
//
// Each accepted item yields one result. An item runs through seven steps on one
// bit-serial divider (elapsed seconds, then per window the new rate, the smoothed
// rate and the time to limit); a step with nothing to divide is skipped. The
// divider yields one quotient bit per cycle over DW bits, with
// DW = max(TIME_BITS, 26 + RATE_FRAC_BITS, 35) = 48 by default. The rate is
// unsigned fixed point with RATE_FRAC_BITS fraction bits; times are 48-bit
// milliseconds. A new item is taken while the previous result waits in the output
// register.
module usage_burn_rate_predictor #(
   parameter int unsigned RATE_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ubrp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ubrp_pkg::rsp_type rsp_data
);

   localparam int unsigned EB = ubrp_pkg::ETA_BITS;

   ubrp_pkg::proj_type proj;
   logic               proj_done;
   logic               out_free;
   logic               warn_s, warn_l;
   ubrp_pkg::rsp_type  rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   ubrp_core #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .proj_done (proj_done),
      .out_free  (out_free),
      .proj      (proj)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      warn_s = (proj.eta_short != '0) && (proj.rem_short != '0) &&
               (proj.eta_short < EB'(proj.rem_short));
      warn_l = (proj.eta_long != '0) && (proj.rem_long != '0) &&
               (proj.eta_long < EB'(proj.rem_long));
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (proj_done && out_free) begin
         rsp_valid_in = 1'b1;
         // earlier exhaustion wins, a tie goes to the short window
         if (warn_s && (!warn_l || proj.eta_short <= proj.eta_long)) begin
            rsp_in.runout_warn    = 1'b1;
            rsp_in.exhaust_window = 1'b0;
            rsp_in.runout_eta_s   = proj.eta_short;
         end else if (warn_l) begin
            rsp_in.runout_warn    = 1'b1;
            rsp_in.exhaust_window = 1'b1;
            rsp_in.runout_eta_s   = proj.eta_long;
         end else begin
            rsp_in.runout_warn    = 1'b0;
            rsp_in.exhaust_window = 1'b0;
            rsp_in.runout_eta_s   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hdl/ubrp_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
module ubrp_div #(
   parameter int unsigned DW = 48,
   parameter int unsigned VW = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int unsigned CW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] dvs_ff, dvs_in;

   logic [VW:0]   shifted;
   logic          ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      ge      = shifted >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = ge ? VW'(shifted - {1'b0, dvs_ff}) : shifted[VW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/ubrp_core.sv -----
`timescale 1ns / 1ps
// Tracker state and operation sequencer around the shared serial divider.
module ubrp_core #(
   parameter int unsigned RATE_FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  ubrp_pkg::req_type  in_data,
   output logic               proj_done,
   input  logic               out_free,
   output ubrp_pkg::proj_type proj
);

   localparam int unsigned F        = RATE_FRAC_BITS;
   localparam int unsigned TB       = ubrp_pkg::TIME_BITS;
   localparam int unsigned UB       = ubrp_pkg::USED_BITS;
   localparam int unsigned RB       = ubrp_pkg::RATE_BITS;
   localparam int unsigned SB       = ubrp_pkg::RESET_BITS;
   localparam int unsigned NUM_BITS = UB + ubrp_pkg::MS_BITS + F;
   localparam int unsigned SM_BITS  = RB + 3;
   localparam int unsigned EN_BITS  = UB + F;
   localparam int unsigned DW_A     = (NUM_BITS > TB) ? NUM_BITS : TB;
   localparam int unsigned DW_B     = (SM_BITS > EN_BITS) ? SM_BITS : EN_BITS;
   localparam int unsigned DW       = (DW_A > DW_B) ? DW_A : DW_B;
   localparam int unsigned VW       = (TB > RB) ? TB : RB;
   localparam logic [RB-1:0] RATE_MIN = RB'((1 << F) / ubrp_pkg::RATE_MIN_INV);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   localparam logic [2:0] STEP_EL    = 3'd0;
   localparam logic [2:0] STEP_INST0 = 3'd1;
   localparam logic [2:0] STEP_SM0   = 3'd2;
   localparam logic [2:0] STEP_ETA0  = 3'd3;
   localparam logic [2:0] STEP_INST1 = 3'd4;
   localparam logic [2:0] STEP_SM1   = 3'd5;
   localparam logic [2:0] STEP_ETA1  = 3'd6;

   logic [1:0]        state_ff, state_in;
   logic [2:0]        step_ff, step_in;
   ubrp_pkg::req_type req_ff, req_in;
   logic              smp_en_ff, smp_en_in;
   logic [TB-1:0]     last_ff, last_in;
   logic              valid_ff [2];
   logic              valid_in [2];
   logic [TB-1:0]     time_ff [2];
   logic [TB-1:0]     time_in [2];
   logic [UB-1:0]     used_ff [2];
   logic [UB-1:0]     used_in [2];
   logic [RB-1:0]     rate_ff [2];
   logic [RB-1:0]     rate_in [2];
   logic [RB-1:0]     eta_ff [2];
   logic [RB-1:0]     eta_in [2];
   logic [SB-1:0]     rem_ff [2];
   logic [SB-1:0]     rem_in [2];
   logic [RB-1:0]     inst_ff, inst_in;
   logic              smooth_ff, smooth_in;

   logic              trk;
   logic [UB-1:0]     u_k, lim_k, diff_used;
   logic [TB-1:0]     gap, elapsed;
   logic [NUM_BITS-1:0] num;
   logic [SM_BITS-1:0]  sm;
   logic [EN_BITS-1:0]  eta_num;
   logic              advance;

   logic              div_start;
   logic [DW-1:0]     div_dividend;
   logic [VW-1:0]     div_divisor;
   logic              div_done;
   logic [DW-1:0]     div_q;

   function automatic logic [RB-1:0] sat_rate(input logic [DW-1:0] q);
      sat_rate = (|q[DW-1:RB]) ? '1 : q[RB-1:0];
   endfunction

   function automatic logic [SB-1:0] remaining(input logic [SB-1:0] rst_s,
                                               input logic [DW-1:0] el);
      if (rst_s == '0 || el >= DW'(rst_s)) begin
         remaining = '0;
      end else begin
         remaining = rst_s - el[SB-1:0];
      end
   endfunction

   ubrp_div #(.DW(DW), .VW(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      trk       = (step_ff >= STEP_INST1);
      u_k       = trk ? req_ff.used_long : req_ff.used_short;
      lim_k     = trk ? req_ff.limit_long : req_ff.limit_short;
      diff_used = u_k - used_ff[trk];
      gap       = req_ff.update_ms - time_ff[trk];
      elapsed   = (req_ff.now_ms >= req_ff.update_ms) ?
                  (req_ff.now_ms - req_ff.update_ms) : '0;
      num       = NUM_BITS'(NUM_BITS'(diff_used) * NUM_BITS'(ubrp_pkg::MS_PER_S)) << F;
      sm        = (SM_BITS'(rate_ff[trk]) << 1) + SM_BITS'(rate_ff[trk]) +
                  (SM_BITS'(inst_ff) << 1);
      eta_num   = EN_BITS'(lim_k - u_k) << F;

      state_in  = state_ff;
      step_in   = step_ff;
      req_in    = req_ff;
      smp_en_in = smp_en_ff;
      last_in   = last_ff;
      valid_in  = valid_ff;
      time_in   = time_ff;
      used_in   = used_ff;
      rate_in   = rate_ff;
      eta_in    = eta_ff;
      rem_in    = rem_ff;
      inst_in   = inst_ff;
      smooth_in = smooth_ff;
      advance   = 1'b0;

      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               req_in    = in_data;
               smp_en_in = (in_data.update_ms != '0) && (in_data.update_ms != last_ff);
               if (smp_en_in) begin
                  last_in = in_data.update_ms;
               end
               step_in  = STEP_EL;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            case (step_ff)
               STEP_EL: begin
                  div_start    = 1'b1;
                  div_dividend = DW'(elapsed);
                  div_divisor  = VW'(ubrp_pkg::MS_PER_S);
               end
               STEP_INST0, STEP_INST1: begin
                  smooth_in = 1'b0;
                  if (smp_en_ff) begin
                     if (!valid_ff[trk]) begin
                        valid_in[trk] = 1'b1;
                        time_in[trk]  = req_ff.update_ms;
                        used_in[trk]  = u_k;
                     end else if (req_ff.update_ms <= time_ff[trk]) begin
                        // stale sample: leave the tracker alone
                     end else if (u_k < used_ff[trk]) begin
                        // usage dropped: restart the tracker
                        time_in[trk] = req_ff.update_ms;
                        used_in[trk] = u_k;
                        rate_in[trk] = '0;
                     end else if (gap >= TB'(ubrp_pkg::GAP_MIN_MS)) begin
                        div_start    = 1'b1;
                        div_dividend = DW'(num);
                        div_divisor  = VW'(gap);
                     end
                  end
               end
               STEP_SM0, STEP_SM1: begin
                  if (smooth_ff) begin
                     div_start    = 1'b1;
                     div_dividend = DW'(sm);
                     div_divisor  = VW'(ubrp_pkg::SMOOTH_DIV);
                  end
               end
               STEP_ETA0, STEP_ETA1: begin
                  if (rate_ff[trk] > RATE_MIN && u_k < lim_k) begin
                     div_start    = 1'b1;
                     div_dividend = DW'(eta_num);
                     div_divisor  = VW'(rate_ff[trk]);
                  end else begin
                     eta_in[trk] = '0;
                  end
               end
               default: begin
               end
            endcase
            if (div_start) begin
               state_in = S_WAIT;
            end else begin
               advance = 1'b1;
            end
         end
         S_WAIT: begin
            if (div_done) begin
               advance = 1'b1;
               case (step_ff)
                  STEP_EL: begin
                     rem_in[0] = remaining(req_ff.reset_short_s, div_q);
                     rem_in[1] = remaining(req_ff.reset_long_s, div_q);
                  end
                  STEP_INST0, STEP_INST1: begin
                     time_in[trk] = req_ff.update_ms;
                     used_in[trk] = u_k;
                     inst_in      = sat_rate(div_q);
                     if (rate_ff[trk] == '0) begin
                        rate_in[trk] = sat_rate(div_q);
                     end else begin
                        smooth_in = 1'b1;
                     end
                  end
                  STEP_SM0, STEP_SM1: begin
                     rate_in[trk] = div_q[RB-1:0];
                  end
                  STEP_ETA0, STEP_ETA1: begin
                     eta_in[trk] = sat_rate(div_q);
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         if (step_ff == STEP_ETA1) begin
            state_in = S_DONE;
         end else begin
            step_in  = step_ff + 3'd1;
            state_in = S_ISSUE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= STEP_EL;
         last_ff  <= '0;
         for (int k = 0; k < 2; k++) begin
            valid_ff[k] <= 1'b0;
            time_ff[k]  <= '0;
            used_ff[k]  <= '0;
            rate_ff[k]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         last_ff  <= last_in;
         for (int k = 0; k < 2; k++) begin
            valid_ff[k] <= valid_in[k];
            time_ff[k]  <= time_in[k];
            used_ff[k]  <= used_in[k];
            rate_ff[k]  <= rate_in[k];
         end
      end
      req_ff    <= req_in;
      smp_en_ff <= smp_en_in;
      inst_ff   <= inst_in;
      smooth_ff <= smooth_in;
      for (int k = 0; k < 2; k++) begin
         eta_ff[k] <= eta_in[k];
         rem_ff[k] <= rem_in[k];
      end
   end

   assign in_ready       = (state_ff == S_IDLE);
   assign proj_done      = (state_ff == S_DONE);
   assign proj.eta_short = eta_ff[0];
   assign proj.eta_long  = eta_ff[1];
   assign proj.rem_short = rem_ff[0];
   assign proj.rem_long  = rem_ff[1];

endmodule

// ----- bench/ubrp_checker.sv -----
`timescale 1ns / 1ps
// Burn-rate predictor checker: tracks both quota windows, predicts each warning, compares.
module ubrp_checker #(
   parameter int unsigned RATE_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ubrp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ubrp_pkg::rsp_type rsp_data,
   output int unsigned       mismatch_count,
   output int unsigned       pending_count
);
   import ubrp_pkg::*;

   localparam bit SHORT_WIN = 1'b0;
   localparam bit LONG_WIN  = 1'b1;
   localparam logic [63:0] U32_CEIL = 64'hFFFF_FFFF;

   // per-window smoothed burn rate, indexed by window
   bit                   win_seen [2];
   logic [TIME_BITS-1:0] win_time [2];
   logic [USED_BITS-1:0] win_used [2];
   logic [RATE_BITS-1:0] win_rate [2];
   logic [TIME_BITS-1:0] prev_sampled_ms;

   rsp_type     expected_warnings [$];
   int unsigned failures = 0;

   assign mismatch_count = failures;

   task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
      failures++;
      $display("mismatch %0s at %0t ns: expected %0h, got %0h", what, $time, want, got);
   endtask

   function automatic void sample_window(input bit w, input logic [USED_BITS-1:0] used,
                                         input logic [TIME_BITS-1:0] t);
      logic [63:0]          gap, inst, smooth;
      logic [USED_BITS-1:0] growth;
      if (!win_seen[w]) begin
         win_seen[w] = 1'b1;
         win_time[w] = t;
         win_used[w] = used;
         return;
      end
      if (t <= win_time[w]) return;
      // usage went down: the window was reset, restart from here
      if (used < win_used[w]) begin
         win_time[w] = t;
         win_used[w] = used;
         win_rate[w] = '0;
         return;
      end
      gap = 64'(t - win_time[w]);
      if (gap < GAP_MIN_MS) return;
      growth = used - win_used[w];
      inst = ((64'(growth) << RATE_FRAC_BITS) * MS_PER_S) / gap;
      if (inst > U32_CEIL) inst = U32_CEIL;
      if (win_rate[w] == 0) begin
         win_rate[w] = inst[RATE_BITS-1:0];
      end else begin
         smooth = (3 * 64'(win_rate[w]) + 2 * inst) / SMOOTH_DIV;
         win_rate[w] = smooth[RATE_BITS-1:0];
      end
      win_time[w] = t;
      win_used[w] = used;
   endfunction

   function automatic logic [ETA_BITS-1:0] window_eta(input bit w,
                                                      input logic [USED_BITS-1:0] used, limit);
      logic [63:0]          rate, q;
      logic [USED_BITS-1:0] headroom;
      rate = 64'(win_rate[w]);
      if (rate * RATE_MIN_INV <= (64'd1 << RATE_FRAC_BITS) || used >= limit) return '0;
      headroom = limit - used;
      q = (64'(headroom) << RATE_FRAC_BITS) / rate;
      if (q > U32_CEIL) q = U32_CEIL;
      return q[ETA_BITS-1:0];
   endfunction

   function automatic logic [ETA_BITS-1:0] reset_left(input logic [RESET_BITS-1:0] secs,
                                                      input logic [TIME_BITS-1:0] upd, now);
      logic [63:0] elapsed, left;
      if (secs == 0) return '0;
      // clock behind the update counts as no time elapsed
      elapsed = (now >= upd) ? 64'(now - upd) / MS_PER_S : 64'd0;
      if (elapsed >= 64'(secs)) return '0;
      left = 64'(secs) - elapsed;
      return left[ETA_BITS-1:0];
   endfunction

   function automatic rsp_type predict_warning(input req_type r);
      logic [ETA_BITS-1:0] eta_s, eta_l, rem_s, rem_l;
      bit                  warn_s, warn_l;
      rsp_type             e;
      if (r.update_ms != 0 && r.update_ms != prev_sampled_ms) begin
         prev_sampled_ms = r.update_ms;
         sample_window(SHORT_WIN, r.used_short, r.update_ms);
         sample_window(LONG_WIN, r.used_long, r.update_ms);
      end
      eta_s  = window_eta(SHORT_WIN, r.used_short, r.limit_short);
      eta_l  = window_eta(LONG_WIN, r.used_long, r.limit_long);
      rem_s  = reset_left(r.reset_short_s, r.update_ms, r.now_ms);
      rem_l  = reset_left(r.reset_long_s, r.update_ms, r.now_ms);
      warn_s = (eta_s > 0) && (rem_s > 0) && (eta_s < rem_s);
      warn_l = (eta_l > 0) && (rem_l > 0) && (eta_l < rem_l);
      e = '0;
      // earlier exhaustion wins, a tie goes to the short window
      if (warn_s && (!warn_l || eta_s <= eta_l)) begin
         e.runout_warn    = 1'b1;
         e.exhaust_window = SHORT_WIN;
         e.runout_eta_s   = eta_s;
      end else if (warn_l) begin
         e.runout_warn    = 1'b1;
         e.exhaust_window = LONG_WIN;
         e.runout_eta_s   = eta_l;
      end
      return e;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         win_seen        = '{2{1'b0}};
         win_time        = '{2{'0}};
         win_used        = '{2{'0}};
         win_rate        = '{2{'0}};
         prev_sampled_ms = '0;
         expected_warnings.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_warnings.size() == 0) begin
               report("result with no item pending", 64'd0, 64'(rsp_data));
            end else begin
               want = expected_warnings.pop_front();
               if (rsp_data.runout_warn !== want.runout_warn)
                  report("runout_warn", 64'(want.runout_warn), 64'(rsp_data.runout_warn));
               if (rsp_data.exhaust_window !== want.exhaust_window)
                  report("exhaust_window", 64'(want.exhaust_window),
                         64'(rsp_data.exhaust_window));
               if (rsp_data.runout_eta_s !== want.runout_eta_s)
                  report("runout_eta_s", 64'(want.runout_eta_s), 64'(rsp_data.runout_eta_s));
            end
         end
         if (req_valid && req_ready) expected_warnings.push_back(predict_warning(req_data));
         pending_count <= expected_warnings.size();
      end
   end

endmodule

// ----- bench/tb_usage_burn_rate_predictor.sv -----
`timescale 1ns / 1ps
// Testbench top of the usage burn-rate predictor: quota tick stimulus, idling and verdict.
module tb_usage_burn_rate_predictor;
   import ubrp_pkg::*;

   localparam int unsigned RATE_FRAC_BITS   = 16;
   localparam int unsigned RANDOM_ITEMS     = 1430;
   localparam int unsigned DRAIN_CYCLES     = 400;
   localparam int unsigned LONG_HOLD_CYCLES = 1500;
   localparam logic [TIME_BITS-1:0] TOP_HALF      = {1'b1, {(TIME_BITS-1){1'b0}}};
   localparam logic [TIME_BITS-1:0] TIME_ALL_ONES = '1;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   int unsigned mismatch_count;
   int unsigned pending_count;

   // running quota timeline of the random part
   logic [TIME_BITS-1:0] upd_ms;
   logic [USED_BITS-1:0] used_s, used_l;
   bit                   tx_steady = 1'b0;
   bit                   rx_steady = 1'b0;
   int unsigned          taken_count = 0;

   always #6 clock = ~clock;

   usage_burn_rate_predictor #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ubrp_checker #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) watcher (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   task automatic send_request(input req_type item);
      int unsigned gap;
      gap = tx_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and hold until every predicted result has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic req_type quota_item(input logic [USED_BITS-1:0] us, ls, ul, ll,
                                          input logic [RESET_BITS-1:0] rs, rl,
                                          input logic [TIME_BITS-1:0] upd, now);
      req_type r;
      r.used_short    = us;
      r.limit_short   = ls;
      r.used_long     = ul;
      r.limit_long    = ll;
      r.reset_short_s = rs;
      r.reset_long_s  = rl;
      r.update_ms     = upd;
      r.now_ms        = now;
      return r;
   endfunction

   // advance a used count; near the top the window resets instead
   function automatic logic [USED_BITS-1:0] grow_used(input logic [USED_BITS-1:0] u,
                                                      input int unsigned d);
      if (32'(u) + d > 32'hFFFF) return USED_BITS'($urandom_range(0, 1000));
      return u + USED_BITS'(d);
   endfunction

   function automatic logic [USED_BITS-1:0] limit_near(input logic [USED_BITS-1:0] u);
      logic [31:0] s;
      if ($urandom_range(0, 7) == 0) return USED_BITS'($urandom_range(0, u));
      s = 32'(u) + $urandom_range(1, 8000);
      return (s > 32'hFFFF) ? '1 : s[USED_BITS-1:0];
   endfunction

   function automatic logic [RESET_BITS-1:0] reset_draw();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0:       v = 0;
         1:       v = $urandom;
         default: v = $urandom_range(1, 20000);
      endcase
      return v[RESET_BITS-1:0];
   endfunction

   function automatic req_type next_quota_tick();
      req_type     r;
      int unsigned kind;
      logic [63:0] wide;
      kind = $urandom_range(0, 99);
      r = '0;
      r.update_ms = upd_ms;
      if (kind >= 86) begin
         wide = {$urandom, $urandom};
         r.used_short  = wide[15:0];
         r.limit_short = wide[31:16];
         r.used_long   = wide[47:32];
         r.limit_long  = wide[63:48];
         wide = {$urandom, $urandom};
         r.reset_short_s = wide[23:0];
         r.reset_long_s  = wide[55:32];
         wide = {$urandom, $urandom};
         r.now_ms = wide[TIME_BITS-1:0];
         if ($urandom_range(0, 1)) r.update_ms = '0;
         return r;
      end
      if (kind < 40) begin
         upd_ms += $urandom_range(1000, 60000);
         used_s = grow_used(used_s, $urandom_range(0, 400));
         used_l = grow_used(used_l, $urandom_range(0, 150));
         r.update_ms = upd_ms;
      end else if (kind < 65) begin
         if ($urandom_range(0, 3) == 0) r.update_ms = '0;
      end else if (kind < 72) begin
         case ($urandom_range(0, 2))
            0:       used_s = USED_BITS'($urandom_range(0, used_s));
            1:       used_l = USED_BITS'($urandom_range(0, used_l));
            default: begin
               used_s = USED_BITS'($urandom_range(0, used_s));
               used_l = USED_BITS'($urandom_range(0, used_l));
            end
         endcase
         upd_ms += $urandom_range(1000, 60000);
         r.update_ms = upd_ms;
      end else if (kind < 78) begin
         upd_ms += $urandom_range(1, 999);
         used_s = grow_used(used_s, $urandom_range(0, 20));
         r.update_ms = upd_ms;
      end else if (kind < 83) begin
         if (upd_ms > 5000) r.update_ms = upd_ms - $urandom_range(1, 5000);
      end else begin
         // jump far ahead, staying below the top half until the planned step
         if (upd_ms < (TOP_HALF >> 1)) begin
            wide = {$urandom, $urandom};
            upd_ms += TIME_BITS'(wide[45:0] >> $urandom_range(0, 40));
         end
         upd_ms += 1000;
         used_s = grow_used(used_s, $urandom_range(0, 400));
         r.update_ms = upd_ms;
      end
      r.used_short    = used_s;
      r.limit_short   = limit_near(used_s);
      r.used_long     = used_l;
      r.limit_long    = limit_near(used_l);
      r.reset_short_s = reset_draw();
      r.reset_long_s  = reset_draw();
      case ($urandom_range(0, 19))
         0: r.now_ms = (r.update_ms > 5000) ? r.update_ms - $urandom_range(1, 5000) : '0;
         1: begin
            wide = {$urandom, $urandom};
            r.now_ms = wide[TIME_BITS-1:0];
         end
         default: r.now_ms = r.update_ms + $urandom_range(0, 90000);
      endcase
      return r;
   endfunction

   initial begin : receiver
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken_count % 64 == 0) rx_steady = ($urandom_range(0, 3) == 0);
         // long hold-offs let the block fill up and push back on the sender
         if (taken_count == 300 || taken_count == 1000) stall = LONG_HOLD_CYCLES;
         else stall = rx_steady ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken_count++;
      end
   end

   initial begin : stimulus
      int unsigned idx;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_request(quota_item(0, 0, 0, 0, 0, 0, 0, 0));
      send_request(quota_item(100, 2000, 100, 2000, 3600, 3600, 1000, 1000));
      send_request(quota_item(100, 2000, 100, 2000, 3600, 3600, 1000, 5000));
      send_request(quota_item(160, 2000, 160, 2000, 3600, 3600, 31000, 31000));
      send_request(quota_item(220, 2000, 170, 2000, 3600, 3600, 61000, 70000));
      send_request(quota_item(230, 2000, 175, 2000, 3600, 3600, 61500, 62000));
      send_request(quota_item(240, 2000, 180, 2000, 3600, 3600, 50000, 62000));
      send_request(quota_item(10, 2000, 300, 2000, 3600, 3600, 91000, 91000));
      send_request(quota_item(10, 2000, 300, 400, 3600, 600, 91000, 95000));
      send_request(quota_item(3000, 2000, 300, 300, 3600, 3600, 91000, 95000));
      send_request(quota_item(100, 2000, 400, 2000, 3600, 3600, 121000, 100000));
      send_request(quota_item(100, 2000, 400, 2000, 3600, 3600, 121000, TIME_ALL_ONES));
      send_request(quota_item(100, 2000, 400, 2000, 0, 0, 121000, 121000));
      send_request(quota_item(100, 16'hFFFF, 400, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                              121000, 121000));
      send_request(quota_item(100, 2000, 400, 2000, 3600, 3600, 151000, 151000));
      send_request(quota_item(0, 16'hFFFF, 0, 16'hFFFF, 3600, 3600, 181000, 181000));
      // growth of one unit over hours: rate at or below the prediction floor
      send_request(quota_item(1, 16'hFFFF, 1, 16'hFFFF, 3600, 3600, 20181000, 20181000));
      send_request(quota_item(2, 10, 2, 10, 3600, 3600, 30181000, 30181000));
      send_request(quota_item(16'hFFFF, 0, 16'hFFFF, 0, 0, 0, 0, 0));
      send_request(quota_item(0, 0, 0, 0, 0, 0, 0, 0));
      wait_for_results();

      upd_ms = 30181000;
      used_s = 2;
      used_l = 2;
      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         if (idx % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
         if (idx == 700) wait_for_results();
         if (idx == 1000 && upd_ms < TOP_HALF) upd_ms += TOP_HALF;
         send_request(next_quota_tick());
      end
      // every field at its maximum, last since it parks the trackers at the end of time
      send_request('1);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #25_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
